[rtl/fde_pkg.sv]
// Shared constants and the beat type that travels down the difference chain.
`timescale 1ns / 1ps
`default_nettype none
package fde_pkg;

  // Number of difference rows, one cell each
  localparam int unsigned LEVELS   = 32;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DATA_W   = 64;

  // One beat moving from a cell to the next
  typedef struct packed {
    logic              valid;   // beat carries a sample wave
    logic              last;    // wave of the final sample of a sequence
    logic              active;  // value still holds a difference for this row
    logic              odd;     // this row has an odd index
    logic [DATA_W-1:0] value;   // difference entering this row
    logic [DATA_W-1:0] fwd;     // running sum of newest elements
    logic [DATA_W-1:0] back;    // running alternating sum of first elements
  } beat_t;

endpackage
`default_nettype wire

[rtl/finite_difference_extrapolator_core.sv]
// Top level: chain of difference cells feeding one output register.
//
// Finite-difference extrapolator. Samples of a sequence arrive on the input
// channel (in_valid_i / in_stall_o, sample_i, last_i), one per beat; last_i
// marks the final sample. Each sample runs down a chain of LEVELS cells, one
// row of the difference table per cell. Samples may follow each other every
// cycle while in_stall_o is low: one beat per cycle sustained.
// A beat with last_i set produces one result on the output channel
// (out_valid_o / out_stall_i): next_value_o, previous_value_o (64-bit,
// wrapping) and too_long_o, once the sample has passed through every cell
// of the chain and into the output register. Beats without last_i produce
// nothing.
// The chain clears itself behind the final sample, so a new sequence may
// start on the very next cycle.
// Reset empties the chain and the output register; no clearing pass.
// When the receiver stalls, the chain keeps moving until a final-sample beat
// reaches its end while the previous result is still held; the whole chain
// then freezes and in_stall_o rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module finite_difference_extrapolator_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [fde_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                              last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [fde_pkg::DATA_W-1:0]      next_value_o,
  output logic signed [fde_pkg::DATA_W-1:0]      previous_value_o,
  output logic                                   too_long_o
);

  fde_pkg::beat_t              beats [fde_pkg::LEVELS+1];
  fde_pkg::beat_t              exit_beat;
  logic                        advance;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q;
  logic [fde_pkg::DATA_W-1:0]  next_q, prev_q;
  logic                        too_long_q;
  logic                        load_out;

  assign exit_beat = beats[fde_pkg::LEVELS];

  // Freeze only when a result must leave while the held one is stalled
  assign advance    = !(exit_beat.valid && exit_beat.last && out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign load_out   = advance && exit_beat.valid && exit_beat.last;

  // Entry beat built from the input ports
  assign beats[0] = '{valid:  in_valid_i,
                      last:   last_i,
                      active: 1'b1,
                      odd:    1'b0,
                      value:  fde_pkg::DATA_W'(sample_i),
                      fwd:    '0,
                      back:   '0};

  // Difference chain
  for (genvar k = 0; k < fde_pkg::LEVELS; k++) begin : g_cell
    fde_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .beat_i (beats[k]),
      .beat_o (beats[k+1])
    );
  end

  // Too-long tracking: a difference left over past the last row was dropped
  always_comb begin
    ovf_d = ovf_q;
    if (advance && exit_beat.valid) begin
      ovf_d = exit_beat.last ? 1'b0 : (ovf_q | exit_beat.active);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      next_q     <= exit_beat.fwd;
      prev_q     <= exit_beat.back;
      too_long_q <= ovf_q | exit_beat.active;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_value_o     = next_q;
  assign previous_value_o = prev_q;
  assign too_long_o       = too_long_q;

endmodule
`default_nettype wire

[rtl/fde_cell.sv]
// One row of the difference table: keeps newest/first element, passes the difference on.
`timescale 1ns / 1ps
`default_nettype none
module fde_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire fde_pkg::beat_t beat_i,
  output fde_pkg::beat_t     beat_o
);

  logic                        row_valid_q, row_valid_d;
  logic [fde_pkg::DATA_W-1:0]  newest_q, newest_d;
  logic [fde_pkg::DATA_W-1:0]  first_q, first_d;
  logic                        out_valid_q;
  fde_pkg::beat_t              beat_q, beat_d;
  logic [fde_pkg::DATA_W-1:0]  fwd_term;
  logic [fde_pkg::DATA_W-1:0]  back_term;

  // Row update and accumulation for the incoming beat
  always_comb begin
    row_valid_d = row_valid_q;
    newest_d    = newest_q;
    first_d     = first_q;
    beat_d      = beat_i;
    beat_d.odd  = ~beat_i.odd;
    fwd_term    = '0;
    back_term   = row_valid_q ? first_q : '0;

    if (beat_i.active) begin
      fwd_term = beat_i.value;
      newest_d = beat_i.value;
      if (row_valid_q) begin
        beat_d.value = beat_i.value - newest_q;
      end else begin
        // open the row with its first element; nothing left to pass down
        first_d       = beat_i.value;
        row_valid_d   = 1'b1;
        back_term     = beat_i.value;
        beat_d.active = 1'b0;
      end
    end

    beat_d.fwd  = beat_i.fwd + fwd_term;
    beat_d.back = beat_i.odd ? (beat_i.back - back_term) : (beat_i.back + back_term);

    // final sample empties the row for the next sequence
    if (beat_i.last) begin
      row_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= beat_i.valid;
      if (beat_i.valid) begin
        row_valid_q <= row_valid_d;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i && beat_i.valid) begin
      newest_q <= newest_d;
      first_q  <= first_d;
      beat_q   <= beat_d;
    end
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = out_valid_q;
  end

endmodule
`default_nettype wire
